// File: src/nearest_palette_color_search_unit_defines.svh
// Assertion macros shared by the nearest palette color search checker.
// No dependencies; included by the checker file only.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NPCS_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define NPCS_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/npcs_pkg.sv
// Package for the nearest palette color search unit: widths, codes, state type
// and the squared difference helper. No dependencies.
`default_nettype none

package npcs_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int SIZE_W  = 9;
	localparam int COMP_W  = 8;
	localparam int IDX_W   = 8;
	localparam int ENTRY_W = 3 * COMP_W;
	localparam int SQ_W    = 2 * COMP_W;
	localparam int DIST_W  = 18;
	localparam logic [DIST_W-1:0] DIST_NONE = '1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	// register index, taken from paddr[APB_AW-1:2]
	localparam logic REG_PALETTE_SIZE = 1'b0;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} npcs_state_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
		input logic [COMP_W-1:0] b);
		logic [COMP_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

endpackage

`default_nettype wire

// File: src/npcs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module npcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/nearest_palette_color_search_unit.sv
// Nearest palette color search: a write stores an entry if its index is below N (busy stays low).
// A query scans entries 0..N-1, N = min(palette_size, PALETTE_DEPTH), one RAM read a
// cycle; done pulses once the last entry is compared, or earlier on an exact match.
// With N = 0 a query returns index 0 on the next cycle. The palette RAM read port
// sets the one-entry-per-cycle rate. Results cannot be stalled.
// arst_n clears control state and sets palette_size to 256; palette RAM is not cleared.
`default_nettype none

module nearest_palette_color_search_unit #(
	parameter int PALETTE_DEPTH = npcs_pkg::PALETTE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// APB register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [npcs_pkg::APB_AW-1:0] paddr,
	input  wire logic [npcs_pkg::APB_DW-1:0] pwdata,
	output logic      [npcs_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	// command side
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        req_type,
	input  wire logic [npcs_pkg::IDX_W-1:0]  entry_index,
	input  wire logic [npcs_pkg::COMP_W-1:0] red,
	input  wire logic [npcs_pkg::COMP_W-1:0] green,
	input  wire logic [npcs_pkg::COMP_W-1:0] blue,
	// result side
	output logic                             done,
	output logic      [npcs_pkg::IDX_W-1:0]  best_index
);

	import npcs_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(PALETTE_DEPTH);

	npcs_state_t state_q, state_d;

	logic [SIZE_W-1:0]  palette_size_q;
	logic [SIZE_W-1:0]  live;
	logic               accept, wr_en, query_go, rd_en, finish, better;
	logic               reg_wr;
	logic [AW-1:0]      addr_q, last_q;
	logic [COMP_W-1:0]  red_q, green_q, blue_q;
	logic [ENTRY_W-1:0] rd_data;

	logic               v_s1;
	logic [AW-1:0]      idx_s1;
	logic               last_s1;

	logic               v_s2;
	logic [AW-1:0]      idx_s2;
	logic               last_s2;
	logic [SQ_W-1:0]    sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0]  dist_sum;

	logic [DIST_W-1:0]  best_dist_q;
	logic [AW-1:0]      best_idx_q;
	logic               done_q;
	logic [IDX_W-1:0]   best_index_q;

	// register port
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite
		&& (paddr[APB_AW-1:2] == REG_PALETTE_SIZE);
	assign prdata = (paddr[APB_AW-1:2] == REG_PALETTE_SIZE) ?
		APB_DW'(palette_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= SIZE_RESET;
		end else if (reg_wr) begin
			palette_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign live     = (palette_size_q > DEPTH_SZ) ? DEPTH_SZ : palette_size_q;
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign wr_en    = accept && (req_type == REQ_WRITE) && ({1'b0, entry_index} < live);
	assign query_go = accept && (req_type == REQ_QUERY);

	npcs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (wr_en),
		.waddr(entry_index[AW-1:0]),
		.wdata({red, green, blue}),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// stage 2: sum and compare against the running best
	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	assign better   = dist_sum < best_dist_q;
	assign finish   = v_s2 && ((dist_sum == '0) || last_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (query_go && (live != '0)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = !finish;
				if (finish) begin
					state_d = ST_IDLE;
				end else if (addr_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// query capture and read address
	always_ff @(posedge clk) begin
		if (query_go) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			addr_q  <= '0;
			last_q  <= AW'(live - SIZE_W'(1));
		end else if (rd_en) begin
			addr_q  <= addr_q + AW'(1);
		end
	end

	// pipeline valids; an early exit kills what is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1 && !finish;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= addr_q;
		last_s1 <= (addr_q == last_q);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		sq_r_s2 <= sq_diff(red_q,   rd_data[3*COMP_W-1:2*COMP_W]);
		sq_g_s2 <= sq_diff(green_q, rd_data[2*COMP_W-1:COMP_W]);
		sq_b_s2 <= sq_diff(blue_q,  rd_data[COMP_W-1:0]);
	end

	// running best; first entry always wins against the sentinel
	always_ff @(posedge clk) begin
		if (query_go) begin
			best_dist_q <= DIST_NONE;
			best_idx_q  <= '0;
		end else if (v_s2 && better) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish || (query_go && (live == '0));
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			best_index_q <= IDX_W'(better ? idx_s2 : best_idx_q);
		end else if (query_go) begin
			best_index_q <= '0;
		end
	end

	assign done       = done_q;
	assign best_index = best_index_q;

endmodule

`default_nettype wire

// File: src/npcs_checker.sv
// Port-level checks for the nearest palette color search unit, bound to the top.
// Depends on nearest_palette_color_search_unit_defines.svh and npcs_pkg.
`default_nettype none

`include "nearest_palette_color_search_unit_defines.svh"

module npcs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic req_type,
	input wire logic done
);

	import npcs_pkg::*;

	logic wr_acc, q_acc;

	assign wr_acc = start && !busy && (req_type == REQ_WRITE);
	assign q_acc  = start && !busy && (req_type == REQ_QUERY);

	// a palette write never occupies the unit and never produces a word
	`NPCS_ASSERT_NXT(a_wr_no_busy, clk, arst_n, wr_acc, !busy && !done, "write left unit busy")
	// a query either starts a scan or answers at once
	`NPCS_ASSERT_NXT(a_query_runs, clk, arst_n, q_acc, busy || done, "query lost")
	// a result word is shown only once the scan has ended
	`NPCS_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	// the scan ends only by delivering a word
	`NPCS_ASSERT_IMP(a_end_done, clk, arst_n, $fell(busy), done, "scan ended without word")

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.req_type(req_type),
	.done    (done)
);

`default_nettype wire

// File: sim/palette_search_checker.sv
`timescale 1ns / 1ps
// Checker for the nearest palette color search unit: mirrors the palette and the size
// register, predicts each query's best index and compares it. Depends on npcs_pkg.
module palette_search_checker
	import npcs_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	input  logic              start,
	input  logic              busy,
	input  logic              req_type,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [COMP_W-1:0] red,
	input  logic [COMP_W-1:0] green,
	input  logic [COMP_W-1:0] blue,
	input  logic              done,
	input  logic [IDX_W-1:0]  best_index,
	output int                fail_count,
	output int                pending,
	output int                checked
);

	logic [ENTRY_W-1:0] palette_copy [PALETTE_DEPTH];
	logic [SIZE_W-1:0]  size_reg;
	logic [IDX_W-1:0]   expected_index_q [$];
	logic [IDX_W-1:0]   want;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	// sizes past the depth saturate
	function automatic int live_count();
		return (size_reg > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size_reg);
	endfunction

	// lowest index wins ties; a zero distance ends the scan
	function automatic logic [IDX_W-1:0] nearest_entry(input logic [COMP_W-1:0] r,
		input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
		logic [DIST_W-1:0]  best_dist;
		logic [DIST_W-1:0]  cur_dist;
		logic [COMP_W-1:0]  dr;
		logic [COMP_W-1:0]  dg;
		logic [COMP_W-1:0]  db;
		logic [ENTRY_W-1:0] e;
		logic [IDX_W-1:0]   best;
		int                 i;
		best = '0;
		best_dist = '1;
		for (i = 0; i < live_count(); i++) begin
			e = palette_copy[i];
			dr = (r > e[23:16]) ? r - e[23:16] : e[23:16] - r;
			dg = (g > e[15:8]) ? g - e[15:8] : e[15:8] - g;
			db = (b > e[7:0]) ? b - e[7:0] : e[7:0] - b;
			cur_dist = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg)
				+ DIST_W'(db) * DIST_W'(db);
			if (cur_dist == '0)
				return IDX_W'(i);
			if (cur_dist < best_dist) begin
				best_dist = cur_dist;
				best = IDX_W'(i);
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = SIZE_RESET;
			expected_index_q.delete();
			pending = 0;
			fail_count = 0;
			checked = 0;
		end else begin
			// a result word at this edge belongs to an earlier query
			if (done) begin
				if (expected_index_q.size() == 0) begin
					report_mismatch($sformatf("best_index %0d with no query outstanding",
						best_index));
				end else begin
					want = expected_index_q.pop_front();
					checked++;
					if (best_index !== want)
						report_mismatch($sformatf("best_index %0d, expected %0d",
							best_index, want));
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_QUERY)
					expected_index_q.push_back(nearest_entry(red, green, blue));
				else if (int'(entry_index) < live_count())
					palette_copy[entry_index] = {red, green, blue};
			end
			if (psel && penable && pready && paddr[APB_AW-1:2] == REG_PALETTE_SIZE) begin
				if (pwrite)
					size_reg = pwdata[SIZE_W-1:0];
				else if (prdata[SIZE_W-1:0] !== size_reg)
					report_mismatch($sformatf("palette_size read %0d, expected %0d",
						prdata[SIZE_W-1:0], size_reg));
			end
			pending = expected_index_q.size();
		end
	end

endmodule

// File: sim/tb_nearest_palette_color_search_unit.sv
`timescale 1ns / 1ps
// Testbench top for the nearest palette color search unit: clock, reset, APB size
// settings and command stimulus. Depends on npcs_pkg, the unit and palette_search_checker.
module tb_nearest_palette_color_search_unit;
	import npcs_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int ITEM_BUDGET  = 550;
	localparam int DRAIN_CYCLES = PALETTE_DEPTH_DEF + 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic              req_type = REQ_WRITE;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [COMP_W-1:0] red = '0;
	logic [COMP_W-1:0] green = '0;
	logic [COMP_W-1:0] blue = '0;
	logic              done;
	logic [IDX_W-1:0]  best_index;
	int                fail_count;
	int                pending;
	int                checked;
	int                cycles = 0;

	// what the stimulus knows it has stored, so queries never touch an empty entry
	logic [ENTRY_W-1:0] shade [PALETTE_DEPTH_DEF];
	bit                 written [PALETTE_DEPTH_DEF];
	int                 live = PALETTE_DEPTH_DEF;
	bit                 steady = 1'b0;
	bit                 coarse = 1'b0;
	int                 n_query = 0;
	int                 n_write = 0;
	int                 n_ignored = 0;
	int                 n_settings = 0;

	nearest_palette_color_search_unit uut (.*);

	palette_search_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("nearest_palette_color_search_unit verification failed");
			$finish;
		end
	end

	// enters and leaves at a falling edge, with the bus idle before it returns
	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_PALETTE_SIZE, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_palette_size(input int n);
		wait_idle();
		apb_access(1'b1, APB_DW'(n));
		apb_access(1'b0, '0);
		live = (n > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : n;
		n_settings++;
	endtask

	// start stays high after the word is taken; wait_idle lowers it, and the next call may
	task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
		input logic [ENTRY_W-1:0] rgb);
		if (!steady && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		{red, green, blue} <= rgb;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (kind == REQ_QUERY) begin
			n_query++;
		end else if (int'(idx) < live) begin
			shade[idx] = rgb;
			written[idx] = 1'b1;
			n_write++;
		end else begin
			n_ignored++;
		end
	endtask

	// coarse colors sit on a 4-level grid so ties and exact hits are common
	function automatic logic [ENTRY_W-1:0] pick_color();
		if (coarse)
			return {COMP_W'($urandom_range(3) * 85), COMP_W'($urandom_range(3) * 85),
				COMP_W'($urandom_range(3) * 85)};
		return ENTRY_W'($urandom);
	endfunction

	function automatic logic [ENTRY_W-1:0] near_color(input logic [ENTRY_W-1:0] c);
		logic [ENTRY_W-1:0] res;
		int                 v;
		int                 k;
		for (k = 0; k < 3; k++) begin
			v = int'(c[8*k +: 8]) + int'($urandom_range(6)) - 3;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			res[8*k +: 8] = COMP_W'(v);
		end
		return res;
	endfunction

	task automatic fill_palette();
		int i;
		for (i = 0; i < live; i++)
			if (!written[i])
				send_item(REQ_WRITE, IDX_W'(i), pick_color());
	endtask

	initial begin
		int               phase;
		int               size;
		int               pick;
		int               sel;
		int               n;
		int               k;
		logic             kind;
		logic [IDX_W-1:0] idx;
		logic [ENTRY_W-1:0] rgb;

		phase = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_access(1'b0, '0);

		// no entries in use: writes dropped, queries answer 0
		set_palette_size(0);
		send_item(REQ_WRITE, 8'd0, 24'h123456);
		send_item(REQ_WRITE, 8'd255, 24'hFFFFFF);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'h000000);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'hFFFFFF);

		set_palette_size(1);
		send_item(REQ_WRITE, 8'd0, 24'hFF00FF);
		send_item(REQ_WRITE, 8'd1, 24'h00FF00);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'h00FF00);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'hFF00FF);

		// duplicate white checks first-index wins; the 40 gray hits a distance tie
		set_palette_size(4);
		send_item(REQ_WRITE, 8'd0, 24'h000000);
		send_item(REQ_WRITE, 8'd1, 24'hFFFFFF);
		send_item(REQ_WRITE, 8'd2, 24'hFFFFFF);
		send_item(REQ_WRITE, 8'd3, 24'h808080);
		send_item(REQ_WRITE, 8'd200, 24'hABCDEF);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'hFFFFFF);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'hFAFAFA);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'h000001);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'h404040);
		send_item(REQ_QUERY, IDX_W'($urandom), 24'hC0C0C0);

		// every word sent, fills and dropped writes included, counts toward the budget
		while ((n_query + n_write + n_ignored) < ITEM_BUDGET) begin
			phase++;
			case (phase)
				1: size = PALETTE_DEPTH_DEF;
				2: size = 511;
				default: begin
					pick = $urandom_range(99);
					if (pick < 70)
						size = $urandom_range(2, 16);
					else if (pick < 85)
						size = $urandom_range(17, 64);
					else if (pick < 92)
						size = 1;
					else if (pick < 96)
						size = $urandom_range(257, 510);
					else
						size = 0;
				end
			endcase
			set_palette_size(size);
			coarse = $urandom_range(1);
			steady = (phase >= 5 && phase <= 8);
			fill_palette();
			n = (live >= 128) ? $urandom_range(16, 28) : $urandom_range(24, 40);
			for (k = 0; k < n; k++) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					kind = REQ_QUERY;
					idx = IDX_W'($urandom);
					sel = $urandom_range(99);
					if (live == 0 || sel >= 60)
						rgb = pick_color();
					else if (sel < 40)
						rgb = shade[$urandom_range(live - 1)];
					else
						rgb = near_color(shade[$urandom_range(live - 1)]);
				end else begin
					kind = REQ_WRITE;
					rgb = pick_color();
					if (pick < 85 && live > 0)
						idx = IDX_W'($urandom_range(live - 1));
					else
						idx = IDX_W'($urandom);
				end
				send_item(kind, idx, rgb);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("run covered %0d queries, %0d palette writes and %0d dropped writes",
			n_query, n_write, n_ignored);
		$display("over %0d palette size settings; %0d best_index words compared",
			n_settings, checked);
		if (fail_count == 0)
			$display("nearest_palette_color_search_unit verification clean");
		else
			$display("nearest_palette_color_search_unit verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/npcs_pkg.sv
src/npcs_ram.sv
src/nearest_palette_color_search_unit.sv
src/npcs_checker.sv
sim/palette_search_checker.sv
sim/tb_nearest_palette_color_search_unit.sv
